FILE: rtl/cor_pkg.sv
// Shared types and constants for the circle outline rasterizer.
// No dependencies; compiled first.
package cor_pkg;

    localparam int RADIUS_BITS_DEF = 12;
    localparam int COORD_BITS_DEF  = 13;
    localparam int COLOR_BITS      = 16;

    // Command codes carried in the action field
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Control flags handed from the iteration logic to the point emitter
    typedef struct packed {
        logic two_groups;  // emit the closing (b,b) octet as well
        logic fig_done;    // this step finishes the whole figure
    } ctl_t;

endpackage

FILE: rtl/cor_cmd_if.sv
// Command channel of the circle outline rasterizer: start and step items.
// Depends on cor_pkg for default widths.
interface cor_cmd_if #(
    parameter int RADIUS_BITS = cor_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = cor_pkg::COORD_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [COORD_BITS-1:0]  center_x;
    logic signed [COORD_BITS-1:0]  center_y;
    logic [RADIUS_BITS-1:0]        radius;
    logic                          filled;
    logic [cor_pkg::COLOR_BITS-1:0] color;

    modport source (
        output valid, action, center_x, center_y, radius, filled, color,
        input  ready
    );
    modport sink (
        input  valid, action, center_x, center_y, radius, filled, color,
        output ready
    );
endinterface

FILE: rtl/cor_pix_if.sv
// Pixel channel of the circle outline rasterizer: one point per item.
// Depends on cor_pkg for default widths.
interface cor_pix_if #(
    parameter int COORD_BITS = cor_pkg::COORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [COORD_BITS:0]     pixel_x;
    logic signed [COORD_BITS:0]     pixel_y;
    logic [cor_pkg::COLOR_BITS-1:0] pixel_color;
    logic                           step_last;
    logic                           figure_done;

    modport source (
        output valid, pixel_x, pixel_y, pixel_color, step_last, figure_done,
        input  ready
    );
    modport sink (
        input  valid, pixel_x, pixel_y, pixel_color, step_last, figure_done,
        output ready
    );
endinterface

FILE: rtl/cor_emit.sv
// Point emitter: holds one step's octets and sends them one point a cycle while pix is ready.
// Depends on cor_pkg and cor_pix_if.
module cor_emit #(
    parameter int RADIUS_BITS = cor_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = cor_pkg::COORD_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  cor_pkg::ctl_t                  ctl,
    input  logic signed [COORD_BITS-1:0]   cx,
    input  logic signed [COORD_BITS-1:0]   cy,
    input  logic [cor_pkg::COLOR_BITS-1:0] color,
    input  logic [RADIUS_BITS-1:0]         a,
    input  logic [RADIUS_BITS-1:0]         b,
    input  logic [RADIUS_BITS-1:0]         c,
    output logic                           ready,
    cor_pix_if.source                      pix
);
    localparam int PIX_BITS = COORD_BITS + 1;
    localparam int SUM_W    = PIX_BITS + RADIUS_BITS;

    // Batch held for the step in flight
    logic                           full_reg;
    logic [3:0]                     idx_reg;
    cor_pkg::ctl_t                  ctl_reg;
    logic signed [COORD_BITS-1:0]   cx_reg;
    logic signed [COORD_BITS-1:0]   cy_reg;
    logic [cor_pkg::COLOR_BITS-1:0] color_reg;
    logic [RADIUS_BITS-1:0]         a_reg;
    logic [RADIUS_BITS-1:0]         b_reg;
    logic [RADIUS_BITS-1:0]         c_reg;

    // Output register
    logic                           ovalid_reg;
    logic [PIX_BITS-1:0]            px_reg;
    logic [PIX_BITS-1:0]            py_reg;
    logic [cor_pkg::COLOR_BITS-1:0] pcolor_reg;
    logic                           plast_reg;
    logic                           pdone_reg;

    logic                   can_load;
    logic                   emit;
    logic                   last_pt;
    logic [RADIUS_BITS-1:0] p;
    logic [RADIUS_BITS-1:0] q;
    logic [SUM_W-1:0]       sx;
    logic [SUM_W-1:0]       sy;
    logic [SUM_W-1:0]       zp;
    logic [SUM_W-1:0]       zq;
    logic [SUM_W-1:0]       x_next;
    logic [SUM_W-1:0]       y_next;

    assign can_load = !ovalid_reg || pix.ready;
    assign emit     = full_reg && can_load;
    assign last_pt  = ctl_reg.two_groups ? (idx_reg == 4'd15) : (idx_reg == 4'd7);
    assign ready    = !full_reg || (emit && last_pt);

    // First octet uses (a,b), its second half swaps to (b,a); second octet is (c,c)
    always_comb
    begin
        if (idx_reg[3])
        begin
            p = c_reg;
            q = c_reg;
        end
        else if (idx_reg[2])
        begin
            p = b_reg;
            q = a_reg;
        end
        else
        begin
            p = a_reg;
            q = b_reg;
        end
        sx = {{(SUM_W-COORD_BITS){cx_reg[COORD_BITS-1]}}, cx_reg};
        sy = {{(SUM_W-COORD_BITS){cy_reg[COORD_BITS-1]}}, cy_reg};
        zp = {{(SUM_W-RADIUS_BITS){1'b0}}, p};
        zq = {{(SUM_W-RADIUS_BITS){1'b0}}, q};
        x_next = idx_reg[1] ? (sx - zp) : (sx + zp);
        y_next = idx_reg[0] ? (sy - zq) : (sy + zq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg   <= 1'b0;
            idx_reg    <= 4'd0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                full_reg <= 1'b1;
                idx_reg  <= 4'd0;
            end
            else if (emit)
            begin
                if (last_pt)
                    full_reg <= 1'b0;
                else
                    idx_reg <= idx_reg + 4'd1;
            end

            if (emit)
                ovalid_reg <= 1'b1;
            else if (pix.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ctl_reg   <= ctl;
            cx_reg    <= cx;
            cy_reg    <= cy;
            color_reg <= color;
            a_reg     <= a;
            b_reg     <= b;
            c_reg     <= c;
        end
        if (emit)
        begin
            px_reg     <= x_next[PIX_BITS-1:0];
            py_reg     <= y_next[PIX_BITS-1:0];
            pcolor_reg <= color_reg;
            plast_reg  <= last_pt;
            pdone_reg  <= last_pt && ctl_reg.fig_done;
        end
    end

    assign pix.valid       = ovalid_reg;
    assign pix.pixel_x     = px_reg;
    assign pix.pixel_y     = py_reg;
    assign pix.pixel_color = pcolor_reg;
    assign pix.step_last   = plast_reg;
    assign pix.figure_done = pdone_reg;

    a_single_octet: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !ctl_reg.two_groups |-> !idx_reg[3])
        else $error("emitter index ran past a single octet");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ready)
        else $error("batch loaded while previous step still pending");

    a_load_starts_batch: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> full_reg && idx_reg == 4'd0)
        else $error("loaded batch not started at first point");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && pdone_reg |-> plast_reg)
        else $error("figure end flagged on a point that does not end its step");

endmodule

FILE: rtl/circle_outline_rasterizer_top.sv
// Top level of the midpoint circle outline rasterizer.
// Depends on cor_pkg, cor_cmd_if, cor_pix_if and cor_emit.
//
//  channel | dir | payload                                           | accept
//  cmd     | in  | action center_x center_y radius filled color      | valid & ready
//  pix     | out | pixel_x pixel_y pixel_color step_last figure_done  | valid & ready
//
// A start item, or a step while idle, is taken and emits nothing.
// A step while drawing updates the decision state in the cycle it is taken and
// hands 8 or 16 points to the emitter, which sends one point per cycle while
// pix is ready.
// The next item is taken in the cycle the emitter sends its last pending point.
// Reset (rst_n low, asynchronous) clears busy and empties the emitter.
module circle_outline_rasterizer_top #(
    parameter int RADIUS_BITS = cor_pkg::RADIUS_BITS_DEF,
    parameter int COORD_BITS  = cor_pkg::COORD_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    cor_cmd_if.sink   cmd,
    cor_pix_if.source pix
);
    localparam int DEC_BITS = RADIUS_BITS + 5;

    logic                           busy_reg;
    logic signed [COORD_BITS-1:0]   cx_reg;
    logic signed [COORD_BITS-1:0]   cy_reg;
    logic [RADIUS_BITS-1:0]         rad_reg;
    logic [RADIUS_BITS-1:0]         a_reg;
    logic [RADIUS_BITS-1:0]         b_reg;
    logic [DEC_BITS-1:0]            dec_reg;
    logic                           fill_reg;
    logic [cor_pkg::COLOR_BITS-1:0] color_reg;

    logic                   ready;
    logic                   accept;
    logic                   start;
    logic                   step_fire;
    logic                   dec_neg;
    logic [DEC_BITS-1:0]    a4;
    logic [DEC_BITS-1:0]    b4;
    logic [DEC_BITS-1:0]    dec_step;
    logic [RADIUS_BITS-1:0] a_step;
    logic [RADIUS_BITS-1:0] b_step;
    logic [RADIUS_BITS-1:0] rad_dn;
    logic                   end_loop;
    logic                   restart;
    logic [DEC_BITS-1:0]    dec_init_cmd;
    logic [DEC_BITS-1:0]    dec_init_dn;
    cor_pkg::ctl_t          ctl;

    assign cmd.ready = ready;
    assign accept    = cmd.valid && ready;
    assign start     = accept && (cmd.action == cor_pkg::ACT_START);
    assign step_fire = accept && (cmd.action == cor_pkg::ACT_STEP) && busy_reg;

    // One midpoint iteration; a < b holds on entry whenever busy
    always_comb
    begin
        dec_neg  = dec_reg[DEC_BITS-1];
        a4       = {3'b000, a_reg, 2'b00};
        b4       = {3'b000, b_reg, 2'b00};
        dec_step = dec_neg ? (dec_reg + a4 + DEC_BITS'(6))
                           : (dec_reg + a4 - b4 + DEC_BITS'(10));
        a_step   = a_reg + 1'b1;
        b_step   = dec_neg ? b_reg : (b_reg - 1'b1);
        end_loop = (a_step >= b_step);
        restart  = end_loop && fill_reg && (rad_reg > RADIUS_BITS'(1));
        rad_dn   = rad_reg - 1'b1;
        dec_init_cmd = DEC_BITS'(3) - {4'b0000, cmd.radius, 1'b0};
        dec_init_dn  = DEC_BITS'(3) - {4'b0000, rad_dn, 1'b0};
        ctl.two_groups = end_loop && (b_step != '0);
        ctl.fig_done   = end_loop && !restart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= (cmd.radius != '0);
        end
        else if (step_fire && end_loop && !restart)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cx_reg    <= cmd.center_x;
            cy_reg    <= cmd.center_y;
            color_reg <= cmd.color;
            fill_reg  <= cmd.filled;
            rad_reg   <= cmd.radius;
            a_reg     <= '0;
            b_reg     <= cmd.radius;
            dec_reg   <= dec_init_cmd;
        end
        else if (step_fire)
        begin
            if (restart)
            begin
                // Next concentric ring, one pixel smaller
                rad_reg <= rad_dn;
                a_reg   <= '0;
                b_reg   <= rad_dn;
                dec_reg <= dec_init_dn;
            end
            else
            begin
                a_reg   <= a_step;
                b_reg   <= b_step;
                dec_reg <= dec_step;
            end
        end
    end

    cor_emit #(
        .RADIUS_BITS (RADIUS_BITS),
        .COORD_BITS  (COORD_BITS)
    ) u_emit (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (step_fire),
        .ctl   (ctl),
        .cx    (cx_reg),
        .cy    (cy_reg),
        .color (color_reg),
        .a     (a_reg),
        .b     (b_reg),
        .c     (b_step),
        .ready (ready),
        .pix   (pix)
    );

    a_offsets_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> a_reg < b_reg)
        else $error("busy with offset a not below offset b");

    a_zero_radius_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && cmd.radius == '0 |=> !busy_reg)
        else $error("zero radius start left the block busy");

    a_ring_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        step_fire && restart |=> busy_reg && rad_reg == $past(rad_reg) - 1'b1)
        else $error("filled figure did not step down one ring");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for circle_outline_rasterizer_top: directed rows, then random figures.
// Depends on cor_pkg, cor_cmd_if, cor_pix_if and the rasterizer RTL.
module tb_top;

    localparam int CB = cor_pkg::COORD_BITS_DEF;
    localparam int RB = cor_pkg::RADIUS_BITS_DEF;
    localparam int PB = CB + 1;
    localparam int DB = RB + 5;
    localparam int CW = cor_pkg::COLOR_BITS;
    localparam int CLK_PERIOD = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NDIR = 25;

    typedef struct packed {
        logic                 act;
        logic signed [CB-1:0] cx;
        logic signed [CB-1:0] cy;
        logic [RB-1:0]        rad;
        logic                 fill;
        logic [CW-1:0]        col;
    } cmd_t;

    typedef struct packed {
        logic signed [PB-1:0] px;
        logic signed [PB-1:0] py;
        logic [CW-1:0]        col;
        logic                 last;
        logic                 done;
    } pixel_t;

    // want_n < 0: rely on the circle predictor alone
    typedef struct packed {
        cmd_t item;
        int   want_n;
        int   want_x;
        int   want_y;
        logic want_done;
    } row_t;

    localparam row_t DIR_ROWS [NDIR] = '{
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_START,     0,     0,    0, 1'b0, 16'h0000},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_START,     0,     0,    1, 1'b0, 16'hFFFF},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,   4095,  4095, 4095, 1'b1, 16'hFFFF},  8,    -1,     0, 1'b1},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_START,  4095, -4096, 4095, 1'b1, 16'h0000},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  8,     0, -4096, 1'b0},
        '{'{cor_pkg::ACT_STEP,  -4096,  4095,    0, 1'b1, 16'hFFFF}, -1,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_START, -4096,  4095, 4095, 1'b0, 16'hAAAA},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  8, -8191,  4095, 1'b0},
        '{'{cor_pkg::ACT_START,  4095,  4095, 4095, 1'b0, 16'h5555},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  8,     0,  4095, 1'b0},
        '{'{cor_pkg::ACT_START,     5,    -7,    2, 1'b1, 16'h1234},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000}, -1,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000}, 16,     4,    -8, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  8,     4,    -7, 1'b1},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_START,   100,   200,    3, 1'b0, 16'hF800},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000}, -1,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000}, 16,    98,   198, 1'b1},
        '{'{cor_pkg::ACT_START,     0,     0, 4095, 1'b1, 16'h07E0},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000}, -1,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_START,     1,     1,    0, 1'b1, 16'h0001},  0,     0,     0, 1'b0},
        '{'{cor_pkg::ACT_STEP,      0,     0,    0, 1'b0, 16'h0000},  0,     0,     0, 1'b0}
    };

    logic clk = 1'b0;
    logic rst_n;

    cor_cmd_if cmd_bus ();
    cor_pix_if pix_bus ();

    circle_outline_rasterizer_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .pix   (pix_bus)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Circle predictor state
    logic                 circle_busy;
    logic signed [CB-1:0] org_x;
    logic signed [CB-1:0] org_y;
    logic [RB-1:0]        cur_r;
    int                   off_a;
    int                   off_b;
    logic signed [DB-1:0] decision;
    logic                 fill_on;
    logic [CW-1:0]        pen;

    pixel_t pixel_q [$];
    int     err_cnt = 0;
    int     row_err_cnt = 0;
    int     live_items = 0;
    int     src_idle_pct = 0;
    int     snk_stall_pct = 0;
    bit     holdoff_req = 1'b0;
    bit     holdoff_done = 1'b0;
    int     quiet_cycles = 0;

    function automatic void push_point(input int x, input int y);
        pixel_t p;
        p.px = PB'(x);
        p.py = PB'(y);
        p.col = pen;
        p.last = 1'b0;
        p.done = 1'b0;
        pixel_q.push_back(p);
    endfunction

    function automatic void push_octet(input int a, input int b);
        int x0;
        int y0;
        x0 = int'(org_x);
        y0 = int'(org_y);
        push_point(x0 + a, y0 + b);
        push_point(x0 + a, y0 - b);
        push_point(x0 - a, y0 + b);
        push_point(x0 - a, y0 - b);
        push_point(x0 + b, y0 + a);
        push_point(x0 + b, y0 - a);
        push_point(x0 - b, y0 + a);
        push_point(x0 - b, y0 - a);
    endfunction

    function automatic void load_circle(input logic [RB-1:0] r);
        cur_r = r;
        off_a = 0;
        off_b = int'(r);
        decision = DB'(3 - 2 * int'(r));
        circle_busy = (r != '0);
    endfunction

    // Expected points of one accepted item; cnt and tail describe what was queued
    function automatic void predict_item(input cmd_t c, output int cnt, output pixel_t tail);
        int  first;
        bit  fin;
        first = pixel_q.size();
        fin = 1'b0;
        tail = '0;
        live_items++;
        if (c.act == cor_pkg::ACT_START)
        begin
            org_x = c.cx;
            org_y = c.cy;
            pen = c.col;
            fill_on = c.fill;
            load_circle(c.rad);
        end
        else if (circle_busy)
        begin
            if (off_a < off_b)
            begin
                push_octet(off_a, off_b);
                if (decision < 0)
                    decision = DB'(int'(decision) + 4 * off_a + 6);
                else
                begin
                    decision = DB'(int'(decision) + 4 * (off_a - off_b) + 10);
                    off_b--;
                end
                off_a++;
            end
            if (off_a >= off_b)
            begin
                if (off_b != 0)
                    push_octet(off_b, off_b);
                if (fill_on && cur_r > 1)
                    load_circle(cur_r - 1'b1);
                else
                begin
                    circle_busy = 1'b0;
                    cur_r = '0;
                    fin = 1'b1;
                end
            end
        end
        cnt = pixel_q.size() - first;
        if (cnt > 0)
        begin
            pixel_q[pixel_q.size() - 1].last = 1'b1;
            pixel_q[pixel_q.size() - 1].done = fin;
            tail = pixel_q[pixel_q.size() - 1];
        end
    endfunction

    function automatic cmd_t rand_item(input logic act);
        cmd_t c;
        c.act = act;
        c.cx = CB'($urandom);
        c.cy = CB'($urandom);
        c.rad = RB'($urandom);
        c.fill = 1'($urandom);
        c.col = CW'($urandom);
        return c;
    endfunction

    // Offer one item, hold it until taken, then maybe go quiet
    task automatic send_item(input cmd_t c, output int cnt, output pixel_t tail);
        cmd_bus.valid <= 1'b1;
        cmd_bus.action <= c.act;
        cmd_bus.center_x <= c.cx;
        cmd_bus.center_y <= c.cy;
        cmd_bus.radius <= c.rad;
        cmd_bus.filled <= c.fill;
        cmd_bus.color <= c.col;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predict_item(c, cnt, tail);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            cmd_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic draw_figure(input logic [RB-1:0] rad, input logic fill, input int max_steps);
        cmd_t   c;
        int     cnt;
        pixel_t tail;
        int     steps;
        c = rand_item(cor_pkg::ACT_START);
        c.rad = rad;
        c.fill = fill;
        send_item(c, cnt, tail);
        steps = 0;
        while (circle_busy && steps < max_steps)
        begin
            send_item(rand_item(cor_pkg::ACT_STEP), cnt, tail);
            steps++;
        end
    endtask

    task automatic run_phase(input int target);
        cmd_t   c;
        int     cnt;
        pixel_t tail;
        int     pick;
        logic   fill;
        while (live_items < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                fill = ($urandom_range(0, 3) == 0);
                draw_figure(fill ? RB'($urandom_range(1, 6)) : RB'($urandom_range(1, 14)),
                            fill, 40);
            end
            else if (pick < 83)
            begin
                // large radius, abandoned early
                draw_figure(RB'($urandom), 1'($urandom), $urandom_range(1, 6));
            end
            else
            begin
                c = rand_item(1'($urandom));
                if ($urandom_range(0, 1) == 0)
                    c.rad = RB'($urandom_range(0, 5));
                send_item(c, cnt, tail);
            end
        end
    endtask

    // Pixel receiver: random stalls, plus one long hold-off on request
    initial
    begin
        pix_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holdoff_req && !holdoff_done)
            begin
                pix_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holdoff_done = 1'b1;
            end
            else
                pix_bus.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && pix_bus.valid && pix_bus.ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("unexpected pixel x=%0d y=%0d", pix_bus.pixel_x, pix_bus.pixel_y);
                err_cnt++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (pix_bus.pixel_x !== want.px)
                begin
                    $error("pixel_x: expected %0d, got %0d", want.px, pix_bus.pixel_x);
                    err_cnt++;
                end
                if (pix_bus.pixel_y !== want.py)
                begin
                    $error("pixel_y: expected %0d, got %0d", want.py, pix_bus.pixel_y);
                    err_cnt++;
                end
                if (pix_bus.pixel_color !== want.col)
                begin
                    $error("pixel_color: expected %h, got %h", want.col, pix_bus.pixel_color);
                    err_cnt++;
                end
                if (pix_bus.step_last !== want.last)
                begin
                    $error("step_last: expected %0b, got %0b", want.last, pix_bus.step_last);
                    err_cnt++;
                end
                if (pix_bus.figure_done !== want.done)
                begin
                    $error("figure_done: expected %0b, got %0b",
                           want.done, pix_bus.figure_done);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_bus.valid && cmd_bus.ready) || (pix_bus.valid && pix_bus.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int     cnt;
        pixel_t tail;
        rst_n <= 1'b0;
        cmd_bus.valid <= 1'b0;
        cmd_bus.action <= cor_pkg::ACT_STEP;
        cmd_bus.center_x <= '0;
        cmd_bus.center_y <= '0;
        cmd_bus.radius <= '0;
        cmd_bus.filled <= 1'b0;
        cmd_bus.color <= '0;
        circle_busy = 1'b0;
        org_x = '0;
        org_y = '0;
        cur_r = '0;
        off_a = 0;
        off_b = 0;
        decision = '0;
        fill_on = 1'b0;
        pen = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < NDIR; i++)
        begin
            send_item(DIR_ROWS[i].item, cnt, tail);
            if (DIR_ROWS[i].want_n >= 0 && (cnt != DIR_ROWS[i].want_n ||
                (cnt > 0 && (tail.px != PB'(DIR_ROWS[i].want_x) ||
                             tail.py != PB'(DIR_ROWS[i].want_y) ||
                             tail.done != DIR_ROWS[i].want_done))))
            begin
                $error({"row %0d points: expected %0d ending (%0d,%0d) done=%0b, ",
                        "got %0d ending (%0d,%0d) done=%0b"},
                       i, DIR_ROWS[i].want_n, DIR_ROWS[i].want_x, DIR_ROWS[i].want_y,
                       DIR_ROWS[i].want_done, cnt, tail.px, tail.py, tail.done);
                row_err_cnt++;
            end
        end

        // Hold off the pixel side while commands keep coming, so the input backs up
        holdoff_req = 1'b1;
        draw_figure(RB'(10), 1'b0, 40);

        run_phase(90);
        src_idle_pct = 60;
        run_phase(150);
        src_idle_pct = 0;
        snk_stall_pct = 60;
        run_phase(210);
        src_idle_pct = 20;
        snk_stall_pct = 20;
        run_phase(270);
        cmd_bus.valid <= 1'b0;

        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_cnt == 0 && row_err_cnt == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: sim.f
rtl/cor_pkg.sv
rtl/cor_cmd_if.sv
rtl/cor_pix_if.sv
rtl/cor_emit.sv
rtl/circle_outline_rasterizer_top.sv
tb/tb_top.sv
